FILE: rtl/grp_pkg.sv
// ----------------------------------------------------------------------------
// grp_pkg
// shared constants, codes and port bundles of the rectangle placement block
// ----------------------------------------------------------------------------
package grp_pkg;

   // floor size limits
   localparam int MAX_ROWS   = 32;
   localparam int MAX_COLS   = 32;
   localparam int TILE_DEPTH = MAX_ROWS * MAX_COLS;

   // address widths of the two stores
   localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int TILE_AW = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;

   // internal arithmetic widths
   localparam int SUM_W = 9;
   localparam int T_W   = (TILE_AW > 12) ? TILE_AW : 12;

   // field widths
   localparam int CORNER_W = 5;
   localparam int SIZE_W   = 6;
   localparam int CHAN_W   = 8;
   localparam int RGB_W    = 3 * CHAN_W;
   localparam int STATUS_W = 2;
   localparam int CSR_AW   = 1;
   localparam int CSR_DW   = 6;

   // color every tile holds after reset
   localparam logic [RGB_W-1:0] GREEN_RGB = 24'h00FF00;

   // register reset values
   localparam logic [CSR_DW-1:0] FLOOR_ROWS_RESET = 6'd32;
   localparam logic [CSR_DW-1:0] FLOOR_COLS_RESET = 6'd32;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_FLOOR_ROWS = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_FLOOR_COLS = 1'b1;

   // commands
   localparam logic CMD_TEST  = 1'b0;
   localparam logic CMD_PLACE = 1'b1;

   // result codes
   localparam logic [STATUS_W-1:0] STATUS_FIT     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EDGE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERLAP = 2'd2;

   // occupancy store port: one row of tiles per entry
   typedef struct packed {
      logic                we;
      logic [ROW_AW-1:0]   waddr;
      logic [MAX_COLS-1:0] wdata;
      logic [ROW_AW-1:0]   raddr;
   } occ_port_type;

   // color store port: one tile per entry, column-major
   typedef struct packed {
      logic               we;
      logic [TILE_AW-1:0] addr;
      logic [RGB_W-1:0]   data;
   } color_port_type;

endpackage

FILE: rtl/grp_occ_mem.sv
// ----------------------------------------------------------------------------
// grp_occ_mem
// occupancy map, one floor row per word, registered read
// ----------------------------------------------------------------------------
module grp_occ_mem (
   input  logic                  clock,
   input  grp_pkg::occ_port_type occ_port,
   output logic [grp_pkg::MAX_COLS-1:0] rdata
);
   import grp_pkg::*;

   logic [MAX_COLS-1:0] rows_mem [MAX_ROWS];
   logic [MAX_COLS-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (occ_port.we) begin
         rows_mem[occ_port.waddr] <= occ_port.wdata;
      end
      rdata_ff <= rows_mem[occ_port.raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/grp_color_mem.sv
// ----------------------------------------------------------------------------
// grp_color_mem
// per-tile color store, indexed column-major by tile number
// ----------------------------------------------------------------------------
module grp_color_mem (
   input  logic                    clock,
   input  grp_pkg::color_port_type color_port
);
   import grp_pkg::*;

   logic [RGB_W-1:0] color_mem [TILE_DEPTH];

   // single write port
   always_ff @(posedge clock) begin
      if (color_port.we) begin
         color_mem[color_port.addr] <= color_port.data;
      end
   end

endmodule

FILE: rtl/grp_ctrl.sv
// ----------------------------------------------------------------------------
// grp_ctrl
// sequencer: clearing pass, edge check, row-wise overlap check, row-wise
// marking and tile-wise color painting, plus the result register
// ----------------------------------------------------------------------------
module grp_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [grp_pkg::CORNER_W-1:0]   req_corner_row,
   input  logic [grp_pkg::CORNER_W-1:0]   req_corner_col,
   input  logic [grp_pkg::SIZE_W-1:0]     req_rect_rows,
   input  logic [grp_pkg::SIZE_W-1:0]     req_rect_cols,
   input  logic [grp_pkg::CHAN_W-1:0]     req_red,
   input  logic [grp_pkg::CHAN_W-1:0]     req_green,
   input  logic [grp_pkg::CHAN_W-1:0]     req_blue,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [grp_pkg::STATUS_W-1:0]   rsp_status,
   // register writes
   input  logic                           csr_we,
   input  logic [grp_pkg::CSR_AW-1:0]     csr_addr,
   input  logic [grp_pkg::CSR_DW-1:0]     csr_data,
   // memory ports
   output grp_pkg::occ_port_type          occ_port,
   input  logic [grp_pkg::MAX_COLS-1:0]   occ_rdata,
   output grp_pkg::color_port_type        color_port
);
   import grp_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHK_RD,
      ST_CHK_TEST,
      ST_MK_RD,
      ST_MK_WR,
      ST_PAINT,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [CSR_DW-1:0]     floor_rows_ff, floor_rows_in;
   logic [CSR_DW-1:0]     floor_cols_ff, floor_cols_in;
   logic                  cmd_ff, cmd_in;
   logic [CORNER_W-1:0]   row_ff, row_in;
   logic [SIZE_W-1:0]     nrows_ff, nrows_in;
   logic [SIZE_W-1:0]     ncols_ff, ncols_in;
   logic [RGB_W-1:0]      rgb_ff, rgb_in;
   logic [MAX_COLS-1:0]   mask_ff, mask_in;
   logic [CSR_DW-1:0]     eff_rows_ff, eff_rows_in;
   logic [T_W-1:0]        colbase_ff, colbase_in;
   logic [SIZE_W-1:0]     i_ff, i_in;
   logic [SIZE_W-1:0]     j_ff, j_in;
   logic [TILE_AW-1:0]    clr_ff, clr_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic [CSR_DW-1:0]     eff_rows;
   logic [CSR_DW-1:0]     eff_cols;
   logic [SUM_W-1:0]      row_end;
   logic [SUM_W-1:0]      col_end;
   logic                  edge_fail;
   logic [MAX_COLS-1:0]   req_mask;
   logic [SUM_W-1:0]      cur_row;
   logic [T_W-1:0]        cur_tile;
   logic                  last_row;
   logic                  last_col;

   // floor size in use, saturated to the store size
   assign eff_rows = (floor_rows_ff > CSR_DW'(MAX_ROWS)) ? CSR_DW'(MAX_ROWS) : floor_rows_ff;
   assign eff_cols = (floor_cols_ff > CSR_DW'(MAX_COLS)) ? CSR_DW'(MAX_COLS) : floor_cols_ff;

   // edge check on the incoming request
   assign row_end   = SUM_W'(req_corner_row) + SUM_W'(req_rect_rows);
   assign col_end   = SUM_W'(req_corner_col) + SUM_W'(req_rect_cols);
   assign edge_fail = (row_end > SUM_W'(eff_rows)) || (col_end > SUM_W'(eff_cols));

   // column mask of the requested rectangle
   always_comb begin
      for (int b = 0; b < MAX_COLS; b++) begin
         req_mask[b] = (SUM_W'(b) >= SUM_W'(req_corner_col)) && (SUM_W'(b) < col_end);
      end
   end

   // walk position
   assign cur_row  = SUM_W'(row_ff) + SUM_W'(i_ff);
   assign cur_tile = colbase_ff + T_W'(row_ff) + T_W'(i_ff);
   assign last_row = (i_ff == nrows_ff - SIZE_W'(1));
   assign last_col = (j_ff == ncols_ff - SIZE_W'(1));

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      floor_rows_in = floor_rows_ff;
      floor_cols_in = floor_cols_ff;
      cmd_in        = cmd_ff;
      row_in        = row_ff;
      nrows_in      = nrows_ff;
      ncols_in      = ncols_ff;
      rgb_in        = rgb_ff;
      mask_in       = mask_ff;
      eff_rows_in   = eff_rows_ff;
      colbase_in    = colbase_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      clr_in        = clr_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;

      occ_port.we    = 1'b0;
      occ_port.waddr = cur_row[ROW_AW-1:0];
      occ_port.wdata = occ_rdata | mask_ff;
      occ_port.raddr = cur_row[ROW_AW-1:0];

      color_port.we   = 1'b0;
      color_port.addr = cur_tile[TILE_AW-1:0];
      color_port.data = rgb_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FLOOR_ROWS: floor_rows_in = csr_data;
            CSR_FLOOR_COLS: floor_cols_in = csr_data;
            default: ;
         endcase
      end

      // response taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         // reset pass over both stores
         ST_CLEAR: begin
            color_port.we   = 1'b1;
            color_port.addr = clr_ff;
            color_port.data = GREEN_RGB;
            occ_port.we     = (32'(clr_ff) < MAX_ROWS);
            occ_port.waddr  = clr_ff[ROW_AW-1:0];
            occ_port.wdata  = '0;
            clr_in          = clr_ff + TILE_AW'(1);
            if (clr_ff == TILE_AW'(TILE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // take a transaction and check the floor edge
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_command;
               row_in      = req_corner_row;
               nrows_in    = req_rect_rows;
               ncols_in    = req_rect_cols;
               rgb_in      = {req_red, req_green, req_blue};
               mask_in     = req_mask;
               eff_rows_in = eff_rows;
               colbase_in  = T_W'(req_corner_col) * T_W'(eff_rows);
               i_in        = '0;
               j_in        = '0;
               if (edge_fail) begin
                  status_in = STATUS_EDGE;
                  state_in  = ST_FINISH;
               end else if (req_rect_rows == '0 || req_rect_cols == '0) begin
                  status_in = STATUS_FIT;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_CHK_RD;
               end
            end
         end

         // overlap check, one row per read
         ST_CHK_RD: begin
            state_in = ST_CHK_TEST;
         end

         ST_CHK_TEST: begin
            if ((occ_rdata & mask_ff) != '0) begin
               status_in = STATUS_OVERLAP;
               state_in  = ST_FINISH;
            end else if (last_row) begin
               i_in = '0;
               if (cmd_ff == CMD_PLACE) begin
                  state_in = ST_MK_RD;
               end else begin
                  status_in = STATUS_FIT;
                  state_in  = ST_FINISH;
               end
            end else begin
               i_in     = i_ff + SIZE_W'(1);
               state_in = ST_CHK_RD;
            end
         end

         // mark covered tiles, read-modify-write per row
         ST_MK_RD: begin
            state_in = ST_MK_WR;
         end

         ST_MK_WR: begin
            occ_port.we = 1'b1;
            if (last_row) begin
               i_in     = '0;
               state_in = ST_PAINT;
            end else begin
               i_in     = i_ff + SIZE_W'(1);
               state_in = ST_MK_RD;
            end
         end

         // paint colors, one tile per cycle, column by column
         ST_PAINT: begin
            color_port.we = 1'b1;
            if (last_row) begin
               i_in       = '0;
               j_in       = j_ff + SIZE_W'(1);
               colbase_in = colbase_ff + T_W'(eff_rows_ff);
               if (last_col) begin
                  status_in = STATUS_FIT;
                  state_in  = ST_FINISH;
               end
            end else begin
               i_in = i_ff + SIZE_W'(1);
            end
         end

         // hand the status to the response register
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         floor_rows_ff <= FLOOR_ROWS_RESET;
         floor_cols_ff <= FLOOR_COLS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         floor_rows_ff <= floor_rows_in;
         floor_cols_ff <= floor_cols_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      nrows_ff      <= nrows_in;
      ncols_ff      <= ncols_in;
      rgb_ff        <= rgb_in;
      mask_ff       <= mask_in;
      eff_rows_ff   <= eff_rows_in;
      colbase_ff    <= colbase_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: rtl/grid_rectangle_placement.sv
// sequence: an edge reject or an empty rectangle goes from accept straight to the finish state;
//   a test reads and tests each covered row, and a place that fits then reads and writes each row
//   and paints each tile; the occupancy check and mark take one row word per read
// throughput: one transaction in flight, the next accepted once the status is in the
//   response register
// reset: synchronous; a clearing pass empties the map and paints all
//   tiles green, with req_ready low; register writes are taken during it
// ----------------------------------------------------------------------------
// grid_rectangle_placement
// rectangle placement on a tile occupancy map with a per-tile color store
// ----------------------------------------------------------------------------
module grid_rectangle_placement (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [grp_pkg::CORNER_W-1:0]   req_corner_row,
   input  logic [grp_pkg::CORNER_W-1:0]   req_corner_col,
   input  logic [grp_pkg::SIZE_W-1:0]     req_rect_rows,
   input  logic [grp_pkg::SIZE_W-1:0]     req_rect_cols,
   input  logic [grp_pkg::CHAN_W-1:0]     req_red,
   input  logic [grp_pkg::CHAN_W-1:0]     req_green,
   input  logic [grp_pkg::CHAN_W-1:0]     req_blue,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [grp_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                           csr_we,
   input  logic [grp_pkg::CSR_AW-1:0]     csr_addr,
   input  logic [grp_pkg::CSR_DW-1:0]     csr_data
);
   import grp_pkg::*;

   occ_port_type        occ_port;
   logic [MAX_COLS-1:0] occ_rdata;
   color_port_type      color_port;

   // sequencer
   grp_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_corner_row (req_corner_row),
      .req_corner_col (req_corner_col),
      .req_rect_rows  (req_rect_rows),
      .req_rect_cols  (req_rect_cols),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_data       (csr_data),
      .occ_port       (occ_port),
      .occ_rdata      (occ_rdata),
      .color_port     (color_port)
   );

   // occupancy map
   grp_occ_mem u_occ_mem (
      .clock    (clock),
      .occ_port (occ_port),
      .rdata    (occ_rdata)
   );

   // color store
   grp_color_mem u_color_mem (
      .clock      (clock),
      .color_port (color_port)
   );

endmodule

FILE: rtl/grp_checker.sv
// ----------------------------------------------------------------------------
// grp_checker
// port-level checks of the rectangle placement block
// ----------------------------------------------------------------------------
module grp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [grp_pkg::STATUS_W-1:0]   rsp_status
);
   import grp_pkg::*;

   // a stalled response holds its status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

   // only defined status codes leave the block
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_FIT || rsp_status == STATUS_EDGE ||
                     rsp_status == STATUS_OVERLAP))
      else $error("undefined status code");

   // the clearing pass keeps the request side closed after reset
   a_clear_closed: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // one transaction at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while one is in work");

endmodule

bind grid_rectangle_placement grp_checker u_checker (.*);
